### sv/gri_pkg.sv
// Shared types and constants for the grid ray / wall intersection block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gri_pkg;
	localparam int TILE_SIZE = 64;
	localparam int TILE_SH   = $clog2(TILE_SIZE);
	localparam int FRAC_SH   = 8;
	localparam int TQ_SH     = TILE_SH + FRAC_SH;
	localparam int TAN_SH    = 16;
	localparam int TAN_W     = 24;
	localparam int IN_W      = 21;
	localparam int OUT_W     = 22;
	localparam int CFG_W     = 7;
	localparam int CELL_W    = 6;
	localparam int POS_W     = 44;
	localparam int DIV_W     = TQ_SH + TAN_SH + 1;
	localparam int IDX_W     = POS_W - TQ_SH;
	localparam int QDEPTH    = 2;

	localparam int MAP_MAX_COLS_DEF = 64;
	localparam int MAP_MAX_ROWS_DEF = 64;

	typedef logic signed [POS_W-1:0] pos_t;

	localparam pos_t TILE_Q  = pos_t'(TILE_SIZE) <<< FRAC_SH;
	localparam pos_t NUDGE   = pos_t'(1) <<< FRAC_SH;
	localparam pos_t QLIM    = pos_t'(1) <<< 40;
	localparam pos_t OUT_MAX = (pos_t'(1) <<< (OUT_W - 1)) - pos_t'(1);
	localparam pos_t OUT_MIN = -(pos_t'(1) <<< (OUT_W - 1));

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_HCAST = 2'd1,
		OP_VCAST = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		REG_MAP_COLS = 1'b0,
		REG_MAP_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t               op;
		logic [CELL_W-1:0] row;
		logic [CELL_W-1:0] col;
		logic              blocks;
		pos_t              ix;
		pos_t              iy;
		pos_t              sx;
		pos_t              sy;
		logic              undo_x;
		logic              undo_y;
	} job_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_START1,
		FS_WAIT1,
		FS_START2,
		FS_WAIT2,
		FS_VMUL,
		FS_VFIN,
		FS_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_CHK,
		BS_RD,
		BS_DONE
	} back_state_t;
endpackage
`default_nettype wire

### sv/gri_div.sv
// Restoring divider, one quotient bit per cycle, sign handled on magnitudes.
// Depends on gri_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gri_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [gri_pkg::DIV_W-1:0]  num_mag,
	input  wire logic                       num_neg,
	input  wire logic signed [gri_pkg::TAN_W-1:0] den,
	output logic                            done,
	output gri_pkg::pos_t                   quo
);
	import gri_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TAN_W-1:0] rem_q;
	logic [DIV_W-1:0] qsh_q;
	logic [TAN_W-1:0] dmag_q;
	logic             neg_q;
	pos_t             quo_q;

	logic [TAN_W:0]   trial;
	logic             ge;
	logic [TAN_W:0]   rem_n;
	logic [DIV_W-1:0] qsh_n;

	always_comb begin
		trial = {rem_q, qsh_q[DIV_W-1]};
		ge    = trial >= {1'b0, dmag_q};
		rem_n = ge ? trial - {1'b0, dmag_q} : trial;
		qsh_n = {qsh_q[DIV_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DIV_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			qsh_q  <= num_mag;
			dmag_q <= den[TAN_W-1] ? TAN_W'(~den + 1'b1) : TAN_W'(den);
			neg_q  <= num_neg ^ den[TAN_W-1];
			if (den == '0) begin
				if (num_mag == '0)
					quo_q <= '0;
				else
					quo_q <= num_neg ? -QLIM : QLIM;
			end
		end else if (busy_q) begin
			rem_q <= rem_n[TAN_W-1:0];
			qsh_q <= qsh_n;
			if (cnt_q == CNT_W'(1))
				quo_q <= neg_q ? -pos_t'(qsh_n) : pos_t'(qsh_n);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### sv/gri_front.sv
// Front end: accepts items, computes the first crossing and the tile step.
// Depends on gri_pkg and gri_div.
`timescale 1ns / 1ps
`default_nettype none
module gri_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  operation,
	input  wire logic [gri_pkg::CELL_W-1:0]  cell_row,
	input  wire logic [gri_pkg::CELL_W-1:0]  cell_col,
	input  wire logic                        cell_blocks,
	input  wire logic [gri_pkg::IN_W-1:0]    pos_x,
	input  wire logic [gri_pkg::IN_W-1:0]    pos_y,
	input  wire logic signed [gri_pkg::TAN_W-1:0] tan_angle,
	input  wire logic                        facing_up,
	input  wire logic                        facing_down,
	input  wire logic                        facing_left,
	input  wire logic                        facing_right,
	output logic                             job_valid,
	input  wire logic                        job_ready,
	output gri_pkg::job_t                    job
);
	import gri_pkg::*;

	localparam int PROD_W = TQ_SH + 2 + TAN_W;

	front_state_t state_q, state_n;

	logic [IN_W-1:0]         px_q, py_q;
	logic signed [TAN_W-1:0] tn_q;
	logic                    up_q, down_q, left_q, right_q;
	pos_t                    q1_q;
	pos_t                    prod_q;
	job_t                    job_q;

	logic                    div_start;
	logic [DIV_W-1:0]        div_num;
	logic                    div_neg;
	logic                    div_done;
	pos_t                    div_quo;

	pos_t                    px_w, py_w, iy0, ix0, dy, dyl, dy_mag, dx;
	logic signed [TQ_SH+1:0] dxn;
	logic signed [PROD_W-1:0] prod;
	pos_t                    sx_h, sy_v;

	function automatic pos_t trunc_tan(input pos_t v);
		pos_t a;
		a = v[POS_W-1] ? v + pos_t'((1 << TAN_SH) - 1) : v;
		return a >>> TAN_SH;
	endfunction

	always_comb begin
		px_w   = pos_t'(px_q);
		py_w   = pos_t'(py_q);
		iy0    = {py_w[POS_W-1:TQ_SH], {TQ_SH{1'b0}}};
		if (down_q)
			iy0 = iy0 + TILE_Q;
		dy     = iy0 - py_w;
		dyl    = dy <<< TAN_SH;
		dy_mag = dy[POS_W-1] ? -dyl : dyl;
		ix0    = {px_w[POS_W-1:TQ_SH], {TQ_SH{1'b0}}};
		if (right_q)
			ix0 = ix0 + TILE_Q;
		dx     = ix0 - px_w;
		dxn    = dx[TQ_SH+1:0];
		prod   = dxn * tn_q;
		// flips apply in a fixed order when both flags are set
		sx_h = div_quo;
		if (left_q && sx_h > 0)
			sx_h = -sx_h;
		if (right_q && sx_h < 0)
			sx_h = -sx_h;
		sy_v = trunc_tan(pos_t'(tn_q) <<< TQ_SH);
		if (up_q && sy_v > 0)
			sy_v = -sy_v;
		if (down_q && sy_v < 0)
			sy_v = -sy_v;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (in_valid) begin
					unique case (op_t'(operation))
						OP_HCAST: state_n = FS_START1;
						OP_VCAST: state_n = FS_VMUL;
						OP_WRITE, OP_NONE: state_n = FS_PUSH;
						default: state_n = FS_PUSH;
					endcase
				end
			end
			FS_START1: state_n = FS_WAIT1;
			FS_WAIT1:  if (div_done) state_n = FS_START2;
			FS_START2: state_n = FS_WAIT2;
			FS_WAIT2:  if (div_done) state_n = FS_PUSH;
			FS_VMUL:   state_n = FS_VFIN;
			FS_VFIN:   state_n = FS_PUSH;
			FS_PUSH:   if (job_ready) state_n = FS_IDLE;
			default:   state_n = FS_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		job_valid = 1'b0;
		div_start = 1'b0;
		div_num   = dy_mag[DIV_W-1:0];
		div_neg   = dy[POS_W-1];
		unique case (state_q)
			FS_IDLE:   in_ready = 1'b1;
			FS_START1: div_start = 1'b1;
			FS_START2: begin
				div_start = 1'b1;
				div_num   = DIV_W'(1) << (TQ_SH + TAN_SH);
				div_neg   = 1'b0;
			end
			FS_PUSH:   job_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FS_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && in_valid) begin
			px_q    <= pos_x;
			py_q    <= pos_y;
			tn_q    <= tan_angle;
			up_q    <= facing_up;
			down_q  <= facing_down;
			left_q  <= facing_left;
			right_q <= facing_right;
			job_q.op     <= op_t'(operation);
			job_q.row    <= cell_row;
			job_q.col    <= cell_col;
			job_q.blocks <= cell_blocks;
			job_q.ix     <= '0;
			job_q.iy     <= '0;
			job_q.sx     <= '0;
			job_q.sy     <= '0;
			job_q.undo_x <= 1'b0;
			job_q.undo_y <= 1'b0;
		end
		if (state_q == FS_WAIT1 && div_done)
			q1_q <= div_quo;
		if (state_q == FS_WAIT2 && div_done) begin
			job_q.ix     <= px_w + q1_q;
			job_q.iy     <= up_q ? iy0 - NUDGE : iy0;
			job_q.sx     <= sx_h;
			job_q.sy     <= up_q ? -TILE_Q : TILE_Q;
			job_q.undo_y <= up_q;
		end
		if (state_q == FS_VMUL)
			prod_q <= pos_t'(prod);
		if (state_q == FS_VFIN) begin
			job_q.ix     <= left_q ? ix0 - NUDGE : ix0;
			job_q.iy     <= py_w + trunc_tan(prod_q);
			job_q.sx     <= left_q ? -TILE_Q : TILE_Q;
			job_q.sy     <= sy_v;
			job_q.undo_x <= left_q;
		end
	end

	assign job = job_q;

	gri_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (div_num),
		.num_neg (div_neg),
		.den     (tn_q),
		.done    (div_done),
		.quo     (div_quo)
	);
endmodule
`default_nettype wire

### sv/gri_queue.sv
// Short job queue between the front end and the walker.
// Depends on gri_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gri_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire gri_pkg::job_t  push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output gri_pkg::job_t       pop_data
);
	import gri_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	job_t          slot_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign push_ready = cnt_q != CW'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (pop)
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= push_data;
	end
endmodule
`default_nettype wire

### sv/gri_back.sv
// Back end: holds the tile map, walks a ray tile by tile, drives the result.
// Depends on gri_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gri_back #(
	parameter int MAP_MAX_COLS = gri_pkg::MAP_MAX_COLS_DEF,
	parameter int MAP_MAX_ROWS = gri_pkg::MAP_MAX_ROWS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_valid,
	output logic                             job_ready,
	input  wire gri_pkg::job_t               job,
	input  wire logic [gri_pkg::CFG_W-1:0]   map_cols,
	input  wire logic [gri_pkg::CFG_W-1:0]   map_rows,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [gri_pkg::OUT_W-1:0] hit_x,
	output logic signed [gri_pkg::OUT_W-1:0] hit_y
);
	import gri_pkg::*;

	localparam int DEPTH = MAP_MAX_ROWS * MAP_MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAP_MAX_ROWS);
	localparam int CW    = $clog2(MAP_MAX_COLS);

	back_state_t state_q, state_n;

	logic       map_q [DEPTH];
	logic       rd_q;
	pos_t       ix_q, iy_q, sx_q, sy_q;
	logic       undo_x_q, undo_y_q;
	logic [OUT_W-1:0] res_x_q, res_y_q;
	logic       out_valid_q;
	logic [OUT_W-1:0] hit_x_q, hit_y_q;

	logic [IDX_W-1:0] cols_e, rows_e, r_idx, c_idx;
	pos_t       xmax, ymax;
	logic       stop;
	logic       out_free;
	logic       take;
	logic       mem_we;
	logic [AW-1:0] mem_wa, mem_ra;

	function automatic logic [OUT_W-1:0] sat_out(input pos_t v);
		pos_t s;
		s = v;
		if (v > OUT_MAX)
			s = OUT_MAX;
		else if (v < OUT_MIN)
			s = OUT_MIN;
		return s[OUT_W-1:0];
	endfunction

	always_comb begin
		cols_e = (IDX_W'(map_cols) > IDX_W'(MAP_MAX_COLS)) ? IDX_W'(MAP_MAX_COLS)
			: IDX_W'(map_cols);
		rows_e = (IDX_W'(map_rows) > IDX_W'(MAP_MAX_ROWS)) ? IDX_W'(MAP_MAX_ROWS)
			: IDX_W'(map_rows);
		xmax   = pos_t'(cols_e) <<< TQ_SH;
		ymax   = pos_t'(rows_e) <<< TQ_SH;
		r_idx  = iy_q[POS_W-1:TQ_SH];
		c_idx  = ix_q[POS_W-1:TQ_SH];
		stop   = ix_q[POS_W-1] || iy_q[POS_W-1] || ix_q > xmax || iy_q > ymax
			|| r_idx >= rows_e || c_idx >= cols_e;
		mem_ra = AW'(r_idx[RW-1:0]) * AW'(MAP_MAX_COLS) + AW'(c_idx[CW-1:0]);
		mem_wa = AW'(job.row) * AW'(MAP_MAX_COLS) + AW'(job.col);
		out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BS_IDLE: begin
				if (job_valid) begin
					if (job.op == OP_HCAST || job.op == OP_VCAST)
						state_n = BS_CHK;
					else
						state_n = BS_DONE;
				end
			end
			BS_CHK:  state_n = stop ? BS_DONE : BS_RD;
			BS_RD:   state_n = rd_q ? BS_DONE : BS_CHK;
			BS_DONE: if (out_free) state_n = BS_IDLE;
			default: state_n = BS_IDLE;
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		take      = 1'b0;
		unique case (state_q)
			BS_IDLE: job_ready = 1'b1;
			BS_DONE: take = out_free;
			default: ;
		endcase
		mem_we = job_ready && job_valid && job.op == OP_WRITE
			&& IDX_W'(job.row) < IDX_W'(MAP_MAX_ROWS)
			&& IDX_W'(job.col) < IDX_W'(MAP_MAX_COLS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (take)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			map_q[mem_wa] <= job.blocks;
		rd_q <= map_q[mem_ra];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				ix_q     <= job.ix;
				iy_q     <= job.iy;
				sx_q     <= job.sx;
				sy_q     <= job.sy;
				undo_x_q <= job.undo_x;
				undo_y_q <= job.undo_y;
				res_x_q  <= '0;
				res_y_q  <= '0;
			end
			BS_CHK: begin
				if (stop) begin
					res_x_q <= sat_out(undo_x_q ? ix_q + NUDGE : ix_q);
					res_y_q <= sat_out(undo_y_q ? iy_q + NUDGE : iy_q);
				end
			end
			BS_RD: begin
				// blocking cell ends the walk, otherwise advance one tile
				if (rd_q) begin
					res_x_q <= sat_out(undo_x_q ? ix_q + NUDGE : ix_q);
					res_y_q <= sat_out(undo_y_q ? iy_q + NUDGE : iy_q);
				end else begin
					ix_q <= ix_q + sx_q;
					iy_q <= iy_q + sy_q;
				end
			end
			BS_DONE: begin
				if (take) begin
					hit_x_q <= res_x_q;
					hit_y_q <= res_y_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign hit_x     = hit_x_q;
	assign hit_y     = hit_y_q;
endmodule
`default_nettype wire

### sv/grid_ray_wall_intersection.sv
// Grid ray / wall intersection top level: configuration registers, front end,
// job queue and walker. Depends on gri_pkg, gri_front, gri_queue, gri_back.
//
// Input and result channels use valid/ready; an item transfers when both are
// high. Every input item gives exactly one result: a map write (operation 0)
// and the unused operation give a zero point, a cast gives the stop point.
// Casts of horizontal lines set up with a division for the first crossing and
// one for the tile step on the shared restoring divider (one quotient bit a
// cycle, 31 bits at the default tile size); casts of vertical lines set up in
// a multiply state and a finish state. The walker checks and then reads each
// tile it visits, as the map read is registered, then loads the result.
// The front end sets up the next item while the walker is busy; a two-entry
// queue and the output register let each side stall on its own. When the
// receiver stalls, the result holds and the queue fills before input stalls.
// Reset sets both map bounds to 64 and empties the pipeline; the map itself
// is not cleared and must be written before a cast reads it.
`timescale 1ns / 1ps
`default_nettype none
module grid_ray_wall_intersection #(
	parameter int MAP_MAX_COLS = gri_pkg::MAP_MAX_COLS_DEF,
	parameter int MAP_MAX_ROWS = gri_pkg::MAP_MAX_ROWS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic                        cfg_index,
	input  wire logic [gri_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  operation,
	input  wire logic [gri_pkg::CELL_W-1:0]  cell_row,
	input  wire logic [gri_pkg::CELL_W-1:0]  cell_col,
	input  wire logic                        cell_blocks,
	input  wire logic [gri_pkg::IN_W-1:0]    pos_x,
	input  wire logic [gri_pkg::IN_W-1:0]    pos_y,
	input  wire logic signed [gri_pkg::TAN_W-1:0] tan_angle,
	input  wire logic                        facing_up,
	input  wire logic                        facing_down,
	input  wire logic                        facing_left,
	input  wire logic                        facing_right,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [gri_pkg::OUT_W-1:0] hit_x,
	output logic signed [gri_pkg::OUT_W-1:0] hit_y
);
	import gri_pkg::*;

	logic [CFG_W-1:0] map_cols_q, map_rows_q;
	job_t             fj, bj;
	logic             fj_valid, fj_ready, bj_valid, bj_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= CFG_W'(64);
			map_rows_q <= CFG_W'(64);
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAP_COLS: map_cols_q <= cfg_wdata;
				REG_MAP_ROWS: map_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gri_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.cell_blocks  (cell_blocks),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.tan_angle    (tan_angle),
		.facing_up    (facing_up),
		.facing_down  (facing_down),
		.facing_left  (facing_left),
		.facing_right (facing_right),
		.job_valid    (fj_valid),
		.job_ready    (fj_ready),
		.job          (fj)
	);

	gri_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_ready (fj_ready),
		.push_data  (fj),
		.pop_valid  (bj_valid),
		.pop_ready  (bj_ready),
		.pop_data   (bj)
	);

	gri_back #(
		.MAP_MAX_COLS (MAP_MAX_COLS),
		.MAP_MAX_ROWS (MAP_MAX_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job       (bj),
		.map_cols  (map_cols_q),
		.map_rows  (map_rows_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit_x     (hit_x),
		.hit_y     (hit_y)
	);
endmodule
`default_nettype wire

### verif/grid_ray_wall_intersection_tb.sv
// Testbench for grid_ray_wall_intersection: loads the tile map, casts rays in
// both modes under several map bounds, and checks each stop point against its own predictor.
// Depends on gri_pkg and the grid_ray_wall_intersection RTL.
`timescale 1ns / 1ps
`default_nettype none
module grid_ray_wall_intersection_tb;
	import gri_pkg::*;

	localparam longint TILE_QL  = 64 * 256;
	localparam longint LIM40    = longint'(1) <<< 40;
	localparam int     STALL_LIM = 5000;

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
	} stop_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = '0;
	logic [CELL_W-1:0] cell_row = '0, cell_col = '0;
	logic cell_blocks = 1'b0;
	logic [IN_W-1:0] pos_x = '0, pos_y = '0;
	logic signed [TAN_W-1:0] tan_angle = '0;
	logic facing_up = 1'b0, facing_down = 1'b0, facing_left = 1'b0, facing_right = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OUT_W-1:0] hit_x, hit_y;

	bit tile_wall [64][64];
	int bound_cols = 64, bound_rows = 64;
	stop_point_t pending_points[$];
	int err_cnt = 0;
	bit steady = 1'b0;
	int stall_cnt = 0;

	always #1 clk = ~clk;

	grid_ray_wall_intersection dut (.*);

	function automatic longint clamp40(longint v);
		if (v > LIM40) return LIM40;
		if (v < -LIM40) return -LIM40;
		return v;
	endfunction

	function automatic longint div_by_tan(longint num, longint den);
		if (den == 0) return num > 0 ? LIM40 : (num < 0 ? -LIM40 : 0);
		return clamp40(num / den);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(longint v);
		if (v > 2097151) v = 2097151;
		if (v < -2097152) v = -2097152;
		return v[OUT_W-1:0];
	endfunction

	// Compute the stop point of one accepted item and update the map for writes.
	function automatic stop_point_t predict_stop(logic [1:0] op, logic [5:0] r6, logic [5:0] c6,
			logic blk, logic [IN_W-1:0] x_in, logic [IN_W-1:0] y_in,
			logic signed [TAN_W-1:0] t_in, logic up, logic down, logic left, logic right);
		stop_point_t sp;
		longint px, py, tn, ix, iy, sx, sy, xmax, ymax, r, c, cols, rows;
		bit horiz;
		sp.x = '0;
		sp.y = '0;
		if (op == OP_WRITE) begin
			tile_wall[r6][c6] = blk;
			return sp;
		end
		if (op == OP_NONE) return sp;
		px = x_in;
		py = y_in;
		tn = t_in;
		horiz = (op == OP_HCAST);
		if (horiz) begin
			iy = (py / TILE_QL) * TILE_QL;
			if (down) iy += TILE_QL;
			ix = px + div_by_tan((iy - py) * 65536, tn);
			sy = up ? -TILE_QL : TILE_QL;
			sx = div_by_tan(TILE_QL * 65536, tn);
			if (left && sx > 0) sx = -sx;
			if (right && sx < 0) sx = -sx;
			if (up) iy -= 256;
		end else begin
			ix = (px / TILE_QL) * TILE_QL;
			if (right) ix += TILE_QL;
			iy = py + clamp40(((ix - px) * tn) / 65536);
			sx = left ? -TILE_QL : TILE_QL;
			sy = clamp40((TILE_QL * tn) / 65536);
			if (up && sy > 0) sy = -sy;
			if (down && sy < 0) sy = -sy;
			if (left) ix -= 256;
		end
		cols = bound_cols > 64 ? 64 : bound_cols;
		rows = bound_rows > 64 ? 64 : bound_rows;
		xmax = TILE_QL * cols;
		ymax = TILE_QL * rows;
		for (int i = 0; i < 132; i++) begin
			if (ix < 0 || iy < 0 || ix > xmax || iy > ymax) break;
			r = iy / TILE_QL;
			c = ix / TILE_QL;
			if (r >= rows || c >= cols) break;
			if (tile_wall[r][c]) break;
			ix += sx;
			iy += sy;
		end
		if (horiz && up) iy += 256;
		if (!horiz && left) ix += 256;
		sp.x = sat_out(ix);
		sp.y = sat_out(iy);
		return sp;
	endfunction

	task automatic send_item(op_t op, logic [5:0] r6, logic [5:0] c6, logic blk,
			logic [IN_W-1:0] x_in, logic [IN_W-1:0] y_in, logic signed [TAN_W-1:0] t_in,
			logic [3:0] face);
		if (!steady && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 40) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		cell_row <= r6;
		cell_col <= c6;
		cell_blocks <= blk;
		pos_x <= x_in;
		pos_y <= y_in;
		tan_angle <= t_in;
		{facing_up, facing_down, facing_left, facing_right} <= face;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_points.push_back(predict_stop(op, r6, c6, blk, x_in, y_in, t_in,
			face[3], face[2], face[1], face[0]));
	endtask

	// Lower valid and wait for the block to go quiet before touching registers.
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_MAP_COLS) bound_cols = val[CFG_W-1:0];
		else bound_rows = val[CFG_W-1:0];
	endtask

	task automatic random_cast;
		logic [IN_W-1:0] x_in, y_in;
		logic signed [TAN_W-1:0] t_in;
		logic [3:0] face;
		bit horiz;
		horiz = 1'($urandom_range(1));
		x_in = $urandom_range(9) == 0 ? IN_W'($urandom) : IN_W'($urandom_range(147456));
		y_in = $urandom_range(9) == 0 ? IN_W'($urandom) : IN_W'($urandom_range(147456));
		case ($urandom_range(9))
			0: t_in = '0;
			1: t_in = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			2, 3: t_in = TAN_W'($urandom);
			default: t_in = TAN_W'($signed($urandom_range(1 << 19)) - (1 << 18));
		endcase
		if ($urandom_range(99) < 15) begin
			face = 4'($urandom);
		end else if (horiz) begin
			face[3] = 1'($urandom_range(1));
			face[2] = ~face[3];
			face[1] = face[3] ? t_in > 0 : t_in < 0;
			face[0] = ~face[1];
		end else begin
			face[1] = 1'($urandom_range(1));
			face[0] = ~face[1];
			face[3] = face[1] ? t_in > 0 : t_in < 0;
			face[2] = ~face[3];
		end
		send_item(horiz ? OP_HCAST : OP_VCAST, '0, '0, 1'b0, x_in, y_in, t_in, face);
	endtask

	// Write the 8 by 8 corner, row 0 and column 0: every cell that a cast can
	// reach under the bounds used here.
	task automatic test_load_map;
		for (int r = 0; r < 64; r++)
			for (int c = 0; c < 64; c++)
				if ((r < 8 && c < 8) || r == 0 || c == 0)
					send_item(OP_WRITE, 6'(r), 6'(c), $urandom_range(99) < 20,
						'0, '0, '0, '0);
	endtask

	task automatic test_directed;
		send_item(OP_NONE, 6'h3F, 6'h3F, 1'b1, '1, '1, '1, 4'hF);
		send_item(OP_WRITE, 6'd63, 6'd63, 1'b1, '1, '1, '1, 4'hF);
		send_item(OP_WRITE, 6'd5, 6'd5, 1'b0, '0, '0, '0, 4'h0);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd81920, 21'd81920, 24'sd0, 4'b1000);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd81920, 21'd81920, 24'sd0, 4'b0100);
		send_item(OP_VCAST, '0, '0, 1'b0, 21'd81920, 21'd81920, 24'sd0, 4'b0001);
		send_item(OP_VCAST, '0, '0, 1'b0, 21'd81920, 21'd81920, 24'sd0, 4'b0010);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd0, 21'd0, 24'sh7FFFFF, 4'b0101);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd1048576, 21'd1048576, 24'sh800000, 4'b1010);
		send_item(OP_VCAST, '0, '0, 1'b0, 21'd1048576, 21'd0, 24'sh7FFFFF, 4'b1010);
		send_item(OP_VCAST, '0, '0, 1'b0, 21'h1FFFFF, 21'h1FFFFF, 24'sh800000, 4'b0101);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd70000, 21'd90000, 24'sd65536, 4'b1111);
		send_item(OP_VCAST, '0, '0, 1'b0, 21'd70000, 21'd90000, -24'sd65536, 4'b1111);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd100000, 21'd100000, 24'sd1, 4'b0110);
		send_item(OP_VCAST, '0, '0, 1'b0, 21'd100000, 21'd100000, -24'sd1, 4'b1001);
		send_item(OP_HCAST, '0, '0, 1'b0, 21'd100000, 21'd100000, 24'sd37837, 4'b0000);
	endtask

	task automatic test_map_bounds;
		int sweep[6][2] = '{'{0, 0}, '{1, 1}, '{127, 1}, '{1, 127}, '{5, 3}, '{8, 8}};
		foreach (sweep[k]) begin
			drain();
			write_reg(REG_MAP_COLS, sweep[k][0]);
			write_reg(REG_MAP_ROWS, sweep[k][1]);
			repeat (12) random_cast();
		end
		drain();
		write_reg(REG_MAP_COLS, 8);
		write_reg(REG_MAP_ROWS, 8);
	endtask

	task automatic test_random_mix;
		for (int n = 0; n < 250; n++) begin
			steady = (n >= 100 && n < 180);
			if ($urandom_range(99) < 10)
				send_item(OP_WRITE, 6'($urandom), 6'($urandom), 1'($urandom),
					IN_W'($urandom), IN_W'($urandom), TAN_W'($urandom), 4'($urandom));
			else if ($urandom_range(99) < 5)
				send_item(OP_NONE, 6'($urandom), 6'($urandom), 1'($urandom),
					IN_W'($urandom), IN_W'($urandom), TAN_W'($urandom), 4'($urandom));
			else
				random_cast();
		end
		steady = 1'b0;
	endtask

	always @(posedge clk)
		out_ready <= steady || $urandom_range(99) >= 17;

	always @(posedge clk) begin
		stop_point_t want;
		if (out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected result hit_x=%0d hit_y=%0d", hit_x, hit_y);
				err_cnt++;
			end else begin
				want = pending_points.pop_front();
				if (hit_x !== want.x) begin
					$error("hit_x expected %0d actual %0d", want.x, hit_x);
					err_cnt++;
				end
				if (hit_y !== want.y) begin
					$error("hit_y expected %0d actual %0d", want.y, hit_y);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIM) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_MAP_COLS, 8);
		write_reg(REG_MAP_ROWS, 8);
		test_load_map();
		test_directed();
		test_map_bounds();
		test_random_mix();
		drain();
		if (err_cnt == 0 && pending_points.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
